/* rtl/core/bitmap_to_index_list_unit_defines.svh */
// Assertion macros shared by the bitmap to index list unit.
`ifndef BITMAP_TO_INDEX_LIST_UNIT_DEFINES_SVH
`define BITMAP_TO_INDEX_LIST_UNIT_DEFINES_SVH

// Same-cycle implication, checked only when the block is out of reset.
`define BTIL_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("bitmap to index list unit: assertion failed");

// Next-cycle implication, checked only when the block is out of reset.
`define BTIL_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("bitmap to index list unit: assertion failed");

`endif

/* rtl/core/btil_pkg.sv */
// Package with the widths, types and constants of the bitmap to index list unit.
package btil_pkg;

    // Field and counter widths.
    localparam int DATA_W      = 64;
    localparam int BIT_IDX_W   = 6;
    localparam int WORD_W      = 10;
    localparam int ID_W        = 16;
    localparam int LIST_W      = 16;
    localparam int OUT_DATA_W  = ID_W + LIST_W;

    // Largest word number the counter can hold, and the default bitmap size.
    localparam int WORD_NUM_MAX  = 1023;
    localparam int MAX_WORDS_DEF = 1024;

    // Controller states.
    typedef enum logic [0:0] {
        BTIL_IDLE,
        BTIL_SCAN
    } btil_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic emit;
        logic finish;
    } btil_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic rem_zero;
        logic last_bit;
        logic out_free;
    } btil_status_t;

endpackage

/* rtl/core/bitmap_to_index_list_unit.sv */
// Top level of the bitmap to index list unit.
// Takes one 64-bit bitmap word at a time and sends one word for each set
// bit, lowest bit first, carrying the vertex id (word number times 64 plus
// bit position) and the id's position in the output list; the final word of
// an input word is marked with m_tlast, and an input word with s_tlast set
// returns both counters to zero after its results. A word is taken in, then
// the unit takes one priority-encoder step per set bit (an empty word ends
// the scan at once), each loading the single output register. The next
// input word is taken while the last result still waits in that register.
// Back-pressure on the result side stalls the scan.
`include "bitmap_to_index_list_unit_defines.svh"

module bitmap_to_index_list_unit #(
    parameter int MAX_WORDS = btil_pkg::MAX_WORDS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input words.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [btil_pkg::DATA_W-1:0]         s_tdata,   // [63:0] bitmap_word
    input  logic                               s_tlast,   // end_of_bitmap
    // Result words.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [btil_pkg::OUT_DATA_W-1:0]     m_tdata,   // [15:0] vertex_id, [31:16] list_position
    output logic                               m_tlast    // last_in_word
);

    btil_pkg::btil_cmd_t    cmd;
    btil_pkg::btil_status_t status;

    // Controller.
    btil_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath.
    btil_dp #(
        .MAX_WORDS (MAX_WORDS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tready (m_tready),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // A result is only loaded when the output register is empty or being drained.
    `BTIL_ASSERT_SAME(a_emit_slot_free, aclk, aresetn, cmd.emit, !m_tvalid || m_tready)
    // A scan ends only on an empty word or on the word carrying its last set bit.
    `BTIL_ASSERT_SAME(a_finish_cause, aclk, aresetn, cmd.finish, status.rem_zero || (cmd.emit && status.last_bit))
    // An accepted word is loaded into the scan register unchanged.
    `BTIL_ASSERT_NEXT(a_load_word, aclk, aresetn, s_tvalid && s_tready, u_dp.rem_reg == $past(s_tdata))

endmodule

/* rtl/core/btil_ctrl.sv */
// Controller state machine of the bitmap to index list unit.
module btil_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  btil_pkg::btil_status_t status,
    output btil_pkg::btil_cmd_t    cmd
);

    btil_pkg::btil_state_t state_reg;
    btil_pkg::btil_state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= btil_pkg::BTIL_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands. A word is scanned one set bit per cycle while
    // the output register is free, and the scan ends on the cycle that sends
    // the last set bit, or at once for an empty word.
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            btil_pkg::BTIL_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = btil_pkg::BTIL_SCAN;
                end
            end
            btil_pkg::BTIL_SCAN: begin
                if (status.rem_zero) begin
                    cmd.finish = 1'b1;
                    state_next = btil_pkg::BTIL_IDLE;
                end else if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.last_bit) begin
                        cmd.finish = 1'b1;
                        state_next = btil_pkg::BTIL_IDLE;
                    end
                end
            end
            default: begin
                state_next = btil_pkg::BTIL_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/btil_dp.sv */
// Datapath of the bitmap to index list unit: word register, counters and output register.
module btil_dp #(
    parameter int MAX_WORDS = btil_pkg::MAX_WORDS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  btil_pkg::btil_cmd_t                 cmd,
    input  logic [btil_pkg::DATA_W-1:0]         s_tdata,
    input  logic                               s_tlast,
    input  logic                               m_tready,
    output btil_pkg::btil_status_t              status,
    output logic                               m_tvalid,
    output logic [btil_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                               m_tlast
);

    // Top word number: the smaller of the bitmap size less one and the counter's top.
    localparam int TOP_INT = (MAX_WORDS - 1 > btil_pkg::WORD_NUM_MAX) ?
                             btil_pkg::WORD_NUM_MAX : MAX_WORDS - 1;
    localparam logic [btil_pkg::WORD_W-1:0] WORD_TOP = btil_pkg::WORD_W'(TOP_INT);

    logic [btil_pkg::DATA_W-1:0]    rem_reg;
    logic [btil_pkg::DATA_W-1:0]    rem_next;
    logic                           end_reg;
    logic [btil_pkg::WORD_W-1:0]    word_num_reg;
    logic [btil_pkg::WORD_W-1:0]    word_num_next;
    logic [btil_pkg::LIST_W-1:0]    list_len_reg;
    logic [btil_pkg::LIST_W-1:0]    list_len_next;
    logic                           m_valid_reg;
    logic                           m_valid_next;
    logic [btil_pkg::ID_W-1:0]      vertex_id_reg;
    logic [btil_pkg::LIST_W-1:0]    list_pos_reg;
    logic                           last_reg;

    logic [btil_pkg::DATA_W-1:0]    rem_dec;
    logic [btil_pkg::DATA_W-1:0]    rem_cleared;
    logic [btil_pkg::DATA_W-1:0]    low_bit;
    logic [btil_pkg::BIT_IDX_W-1:0] bit_idx;

    // Lowest set bit of the remaining word, isolated with one decrement.
    assign rem_dec     = rem_reg - btil_pkg::DATA_W'(1);
    assign rem_cleared = rem_reg & rem_dec;
    assign low_bit     = rem_reg & ~rem_dec;

    // One-hot to binary encoding of the isolated bit.
    always_comb begin
        bit_idx = '0;
        for (int i = 0; i < btil_pkg::DATA_W; i++) begin
            bit_idx = bit_idx | ({btil_pkg::BIT_IDX_W{low_bit[i]}} & btil_pkg::BIT_IDX_W'(i));
        end
    end

    // Status towards the controller.
    assign status.rem_zero = (rem_reg == '0);
    assign status.last_bit = (rem_cleared == '0);
    assign status.out_free = !m_valid_reg || m_tready;

    // Next values of the word register and the counters.
    always_comb begin
        rem_next      = rem_reg;
        word_num_next = word_num_reg;
        list_len_next = list_len_reg;
        if (cmd.load) begin
            rem_next = s_tdata;
        end else if (cmd.emit) begin
            rem_next = rem_cleared;
        end
        if (cmd.emit) begin
            list_len_next = list_len_reg + btil_pkg::LIST_W'(1);
        end
        if (cmd.finish) begin
            if (end_reg) begin
                word_num_next = '0;
                list_len_next = '0;
            end else if (word_num_reg < WORD_TOP) begin
                word_num_next = word_num_reg + btil_pkg::WORD_W'(1);
            end
        end
    end

    // Output register valid flag.
    always_comb begin
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control state and counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_num_reg <= '0;
            list_len_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            word_num_reg <= word_num_next;
            list_len_reg <= list_len_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        if (cmd.load) begin
            end_reg <= s_tlast;
        end
        if (cmd.emit) begin
            vertex_id_reg <= {word_num_reg, bit_idx};
            list_pos_reg  <= list_len_reg;
            last_reg      <= status.last_bit;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {list_pos_reg, vertex_id_reg};
    assign m_tlast  = last_reg;

endmodule
